### hdl/pida_pkg.sv
package pida_pkg;

	localparam int CAPACITY = 16;

	localparam int MODE_W = 3;
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 32;
	localparam int ST_W   = 3;
	localparam int FILL_W = 5;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int AW     = $clog2(CAPACITY);
	localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd6;
	localparam logic [MODE_W-1:0] MODE_READ      = 3'd7;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_BADIDX   = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	typedef logic [1:0] cell_op_t;

	localparam cell_op_t CELL_HOLD    = 2'd0;
	localparam cell_op_t CELL_LOAD    = 2'd1;
	localparam cell_op_t CELL_FROM_LO = 2'd2;
	localparam cell_op_t CELL_FROM_HI = 2'd3;

	typedef struct packed {
		cell_op_t          op;
		logic [VAL_W-1:0]  din;
	} cell_ctl_t;

endpackage

### hdl/pida_cell.sv
module pida_cell (
	input  logic                            clk,
	input  pida_pkg::cell_ctl_t             ctl,
	input  logic [pida_pkg::VAL_W-1:0]      lo_val,
	input  logic [pida_pkg::VAL_W-1:0]      hi_val,
	output logic [pida_pkg::VAL_W-1:0]      q,
	output logic                            hit
);

	logic [pida_pkg::VAL_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			pida_pkg::CELL_LOAD:    value_q <= ctl.din;
			pida_pkg::CELL_FROM_LO: value_q <= lo_val;
			pida_pkg::CELL_FROM_HI: value_q <= hi_val;
			default:                value_q <= value_q;
		endcase
	end

	// din doubles as the search key
	assign hit = (value_q == ctl.din);
	assign q   = value_q;

endmodule

### hdl/positional_insert_delete_array.sv
// Packed list of signed 32-bit words with insert, delete, search and read.
// Input channel: in_valid/in_stall carry mode, index and value. Output
// channel: out_valid/out_stall carry status, found_index, read_value and
// fill_count, one result word for every input word.
// Results are registered and appear in the cycle after acceptance.
// Throughput: one word per cycle unless a result is stalled. Every entry
// lives in its own cell; all cells load, shift up or shift down in the same
// cycle, and search is a compare in every cell then a lowest-index pick.
// Stall: the result sits in a single output register. While that register
// holds a word the receiver stalls, in_stall is raised and the list and the
// result hold. A new word is taken in the cycle the old result leaves.
// Reset: arst_n clears the entry count and the output valid; the list is
// empty afterward, and entry contents are don't-care until written.
module positional_insert_delete_array (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [pida_pkg::MODE_W-1:0]          mode,
	input  logic [pida_pkg::IDX_W-1:0]           index,
	input  logic signed [pida_pkg::VAL_W-1:0]    value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pida_pkg::ST_W-1:0]            status,
	output logic [pida_pkg::IDX_W-1:0]           found_index,
	output logic signed [pida_pkg::VAL_W-1:0]    read_value,
	output logic [pida_pkg::FILL_W-1:0]          fill_count
);

	localparam int CAP   = pida_pkg::CAPACITY;
	localparam int CMP_W = pida_pkg::CMP_W;
	localparam int CNT_W = pida_pkg::CNT_W;
	localparam int VAL_W = pida_pkg::VAL_W;

	logic                  out_valid_q;
	logic [CNT_W-1:0]      count_q;
	logic [pida_pkg::ST_W-1:0]   status_q;
	logic [pida_pkg::IDX_W-1:0]  found_q;
	logic [VAL_W-1:0]            rdv_q;
	logic [pida_pkg::FILL_W-1:0] fill_q;

	logic                  accept;
	logic                  full, empty;
	logic [CMP_W-1:0]      cnt_ext, idx_ext, pos;
	logic [CNT_W-1:0]      cnt_d;
	logic [pida_pkg::ST_W-1:0] st;
	logic                  ins_ok, del_ok, rd_ok, srch_ok;
	logic [CAP-1:0]        hit_vec, hit_raw;
	logic [CMP_W-1:0]      found_w;
	logic [VAL_W-1:0]      sel_val;

	logic [VAL_W-1:0]      cell_q [CAP];
	logic [VAL_W-1:0]      lo_w   [CAP];
	logic [VAL_W-1:0]      hi_w   [CAP];
	pida_pkg::cell_ctl_t   ctl_w  [CAP];

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign full    = (count_q >= CNT_W'(CAP));
	assign empty   = (count_q == '0);
	assign cnt_ext = CMP_W'(count_q);
	assign idx_ext = CMP_W'(index);

	// lowest matching entry below the fill count
	always_comb begin
		found_w = '0;
		for (int i = CAP - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				found_w = CMP_W'(i);
			end
		end
	end

	always_comb begin
		st      = pida_pkg::ST_OK;
		pos     = '0;
		ins_ok  = 1'b0;
		del_ok  = 1'b0;
		rd_ok   = 1'b0;
		srch_ok = 1'b0;
		unique case (mode) inside
			pida_pkg::MODE_INS_FRONT, pida_pkg::MODE_INS_BACK,
			pida_pkg::MODE_INS_AT: begin
				if (full) begin
					st = pida_pkg::ST_FULL;
				end else if (mode == pida_pkg::MODE_INS_FRONT) begin
					ins_ok = 1'b1;
				end else if (mode == pida_pkg::MODE_INS_BACK) begin
					pos    = cnt_ext;
					ins_ok = 1'b1;
				end else if (idx_ext > cnt_ext) begin
					st = pida_pkg::ST_BADIDX;
				end else begin
					pos    = idx_ext;
					ins_ok = 1'b1;
				end
			end
			pida_pkg::MODE_DEL_FRONT, pida_pkg::MODE_DEL_BACK,
			pida_pkg::MODE_DEL_AT: begin
				if (empty) begin
					st = pida_pkg::ST_EMPTY;
				end else if (mode == pida_pkg::MODE_DEL_FRONT) begin
					del_ok = 1'b1;
				end else if (mode == pida_pkg::MODE_DEL_BACK) begin
					pos    = cnt_ext - CMP_W'(1);
					del_ok = 1'b1;
				end else if (idx_ext >= cnt_ext) begin
					st = pida_pkg::ST_BADIDX;
				end else begin
					pos    = idx_ext;
					del_ok = 1'b1;
				end
			end
			pida_pkg::MODE_SEARCH: begin
				if (|hit_vec) begin
					srch_ok = 1'b1;
				end else begin
					st = pida_pkg::ST_NOTFOUND;
				end
			end
			pida_pkg::MODE_READ: begin
				if (empty) begin
					st = pida_pkg::ST_EMPTY;
				end else if (idx_ext >= cnt_ext) begin
					st = pida_pkg::ST_BADIDX;
				end else begin
					pos   = idx_ext;
					rd_ok = 1'b1;
				end
			end
			default: begin
				st = pida_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		cnt_d = count_q;
		if (ins_ok) begin
			cnt_d = count_q + CNT_W'(1);
		end else if (del_ok) begin
			cnt_d = count_q - CNT_W'(1);
		end
	end

	assign sel_val = cell_q[pos[pida_pkg::AW-1:0]];

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lo_w[i] = value;
		end else begin : g_lo
			assign lo_w[i] = cell_q[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign hi_w[i] = cell_q[i];
		end else begin : g_hi
			assign hi_w[i] = cell_q[i+1];
		end

		always_comb begin
			ctl_w[i].din = value;
			ctl_w[i].op  = pida_pkg::CELL_HOLD;
			if (accept && ins_ok) begin
				if (pos == CMP_W'(i)) begin
					ctl_w[i].op = pida_pkg::CELL_LOAD;
				end else if (pos < CMP_W'(i)) begin
					ctl_w[i].op = pida_pkg::CELL_FROM_LO;
				end
			end else if (accept && del_ok) begin
				if (pos <= CMP_W'(i)) begin
					ctl_w[i].op = pida_pkg::CELL_FROM_HI;
				end
			end
		end

		pida_cell u_cell (
			.clk    (clk),
			.ctl    (ctl_w[i]),
			.lo_val (lo_w[i]),
			.hi_val (hi_w[i]),
			.q      (cell_q[i]),
			.hit    (hit_raw[i])
		);

		// drop matches in entries past the fill count
		assign hit_vec[i] = hit_raw[i] & (CMP_W'(i) < cnt_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				count_q     <= cnt_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st;
			found_q  <= srch_ok ? found_w[pida_pkg::IDX_W-1:0] : '0;
			rdv_q    <= (del_ok || rd_ok) ? sel_val : '0;
			fill_q   <= pida_pkg::FILL_W'(cnt_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign read_value  = rdv_q;
	assign fill_count  = fill_q;

endmodule

### hdl/pida_chk.sv
module pida_chk (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [pida_pkg::ST_W-1:0]            status,
	input  logic [pida_pkg::IDX_W-1:0]           found_index,
	input  logic signed [pida_pkg::VAL_W-1:0]    read_value,
	input  logic [pida_pkg::FILL_W-1:0]          fill_count
);

	// a stalled result holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(found_index) && $stable(read_value) && $stable(fill_count))
		else $error("stalled result changed");

	// every accepted word gives a result in the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted word produced no result");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == pida_pkg::ST_FULL |->
		fill_count == pida_pkg::FILL_W'(pida_pkg::CAPACITY))
		else $error("full reported below capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pida_pkg::ST_OK |-> read_value == '0 && found_index == '0)
		else $error("failed operation returned data");

endmodule

bind positional_insert_delete_array pida_chk u_pida_chk (.*);

### sim/positional_insert_delete_array_test.sv
module positional_insert_delete_array_test;
	import pida_pkg::*;

	localparam int RANDOM_WORDS = 950;
	localparam int IDLE_LIMIT   = 2000;
	localparam int FILL_AT      = 17;

	localparam logic [MODE_W-1:0] INS_MODES [3] = '{MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT};
	localparam logic [MODE_W-1:0] DEL_MODES [3] = '{MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT};

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic [IDX_W-1:0]         found_index;
		logic signed [VAL_W-1:0]  read_value;
		logic [FILL_W-1:0]        fill_count;
	} outcome_t;

	typedef struct packed {
		logic [MODE_W-1:0]        op;
		logic [IDX_W-1:0]         at;
		logic signed [VAL_W-1:0]  data;
		bit                       known;
		outcome_t                 want;
	} step_t;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [MODE_W-1:0]           mode = '0;
	logic [IDX_W-1:0]            index = '0;
	logic signed [VAL_W-1:0]     value = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [ST_W-1:0]             status;
	logic [IDX_W-1:0]            found_index;
	logic signed [VAL_W-1:0]     read_value;
	logic [FILL_W-1:0]           fill_count;

	// shadow copy of the list
	logic signed [VAL_W-1:0]     list_mem [CAPACITY];
	int                          list_len = 0;

	outcome_t                    pending [$];
	step_t                       script [$];
	int                          errors = 0;
	int                          idle_cycles = 0;
	int                          burst_left = 0;

	stall_style_t                stall_style = STALL_NONE;
	int                          style_left = 0;
	int                          run_left = 0;
	bit                          stall_on = 1'b0;

	positional_insert_delete_array dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.index       (index),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_index (found_index),
		.read_value  (read_value),
		.fill_count  (fill_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic outcome_t apply_op(logic [MODE_W-1:0] m, logic [IDX_W-1:0] ix,
			logic signed [VAL_W-1:0] v);
		outcome_t res;
		int pos;
		int i;
		res = '0;
		res.status = ST_OK;
		case (m)
		MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
			if (list_len >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				pos = (m == MODE_INS_FRONT) ? 0 : (m == MODE_INS_BACK) ? list_len : int'(ix);
				if (pos > list_len) begin
					res.status = ST_BADIDX;
				end else begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[pos] = v;
					list_len++;
				end
			end
		end
		MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
			if (list_len == 0) begin
				res.status = ST_EMPTY;
			end else begin
				pos = (m == MODE_DEL_FRONT) ? 0 : (m == MODE_DEL_BACK) ? list_len - 1 : int'(ix);
				if (pos >= list_len) begin
					res.status = ST_BADIDX;
				end else begin
					res.read_value = list_mem[pos];
					for (i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
		end
		MODE_SEARCH: begin
			res.status = ST_NOTFOUND;
			for (i = 0; i < list_len; i++) begin
				if (res.status == ST_NOTFOUND && list_mem[i] == v) begin
					res.status = ST_OK;
					res.found_index = IDX_W'(i);
				end
			end
		end
		default: begin
			if (list_len == 0)
				res.status = ST_EMPTY;
			else if (int'(ix) >= list_len)
				res.status = ST_BADIDX;
			else
				res.read_value = list_mem[ix];
		end
		endcase
		res.fill_count = FILL_W'(list_len);
		return res;
	endfunction

	function automatic void add_step(logic [MODE_W-1:0] op, logic [IDX_W-1:0] at,
			logic signed [VAL_W-1:0] data, bit known, logic [ST_W-1:0] st,
			logic [IDX_W-1:0] fi, logic signed [VAL_W-1:0] rv, logic [FILL_W-1:0] fc);
		script.push_back({op, at, data, known, st, fi, rv, fc});
	endfunction

	function automatic void check_field(string what, logic signed [VAL_W:0] want,
			logic signed [VAL_W:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	task automatic send_word(logic [MODE_W-1:0] m, logic [IDX_W-1:0] ix,
			logic signed [VAL_W-1:0] v, bit known, outcome_t want);
		outcome_t predicted;
		int gap;
		mode <= m;
		index <= ix;
		value <= v;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_op(m, ix, v);
		pending.push_back(known ? want : predicted);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				// idle with junk on the payload
				in_valid <= 1'b0;
				mode <= MODE_W'($urandom);
				index <= IDX_W'($urandom);
				value <= $urandom;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending.size() != 0);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return $urandom_range(0, 7);
		4: begin
			case ($urandom_range(0, 3))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			default: return -32'sd1;
			endcase
		end
		default: return $urandom;
		endcase
	endfunction

	// sender
	initial begin
		outcome_t none;
		step_t s;
		logic [MODE_W-1:0] m;
		logic [IDX_W-1:0] ix;
		logic signed [VAL_W-1:0] v;
		int r;
		int span;
		bit grow;
		none = '0;
		grow = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_step(MODE_READ,      0, 0, 1, ST_EMPTY,    0, 0, 0);
		add_step(MODE_DEL_FRONT, 0, 0, 1, ST_EMPTY,    0, 0, 0);
		add_step(MODE_DEL_BACK,  0, 0, 1, ST_EMPTY,    0, 0, 0);
		add_step(MODE_DEL_AT,    0, 0, 1, ST_EMPTY,    0, 0, 0);
		add_step(MODE_SEARCH,    0, 0, 1, ST_NOTFOUND, 0, 0, 0);
		add_step(MODE_INS_AT,    1, 7, 1, ST_BADIDX,   0, 0, 0);
		add_step(MODE_INS_AT,    0, 32'sh8000_0000, 1, ST_OK, 0, 0, 1);
		add_step(MODE_INS_BACK,  0, 32'sh7fff_ffff, 1, ST_OK, 0, 0, 2);
		add_step(MODE_INS_FRONT, 0, 0, 1, ST_OK,       0, 0, 3);
		add_step(MODE_READ,     15, 0, 1, ST_BADIDX,   0, 0, 3);
		add_step(MODE_DEL_AT,    3, 0, 1, ST_BADIDX,   0, 0, 3);
		add_step(MODE_SEARCH,    0, 32'sh7fff_ffff, 1, ST_OK, 2, 0, 3);
		add_step(MODE_READ,      1, 0, 1, ST_OK, 0, 32'sh8000_0000, 3);
		add_step(MODE_INS_AT,    3, 32'sh5555_5555, 0, ST_OK, 0, 0, 0);
		add_step(MODE_DEL_AT,    1, 0, 0, ST_OK, 0, 0, 0);
		add_step(MODE_SEARCH,    0, 32'shaaaa_aaaa, 0, ST_OK, 0, 0, 0);
		add_step(MODE_DEL_BACK,  0, 0, 0, ST_OK, 0, 0, 0);
		// rows from here on start against a full list
		add_step(MODE_INS_FRONT, 0, 1, 1, ST_FULL, 0, 0, CAPACITY);
		add_step(MODE_INS_AT,   15, 1, 1, ST_FULL, 0, 0, CAPACITY);
		add_step(MODE_INS_BACK,  0, 1, 1, ST_FULL, 0, 0, CAPACITY);
		add_step(MODE_READ,     15, 0, 0, ST_OK, 0, 0, 0);
		add_step(MODE_SEARCH,    0, 2, 0, ST_OK, 0, 0, 0);
		add_step(MODE_DEL_AT,   15, 0, 0, ST_OK, 0, 0, 0);
		add_step(MODE_DEL_BACK,  0, 0, 0, ST_OK, 0, 0, 0);
		add_step(MODE_DEL_FRONT, 0, 0, 0, ST_OK, 0, 0, 0);

		for (int k = 0; k < script.size(); k++) begin
			if (k == FILL_AT) begin
				// small values so the search finds duplicates
				while (list_len < CAPACITY)
					send_word(MODE_INS_BACK, IDX_W'($urandom), $urandom_range(0, 3), 0, none);
			end
			s = script[k];
			send_word(s.op, s.at, s.data, s.known, s.want);
		end
		drain_results();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2)
				drain_results();
			if (list_len == CAPACITY)
				grow = 1'b0;
			else if (list_len == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				grow = !grow;
			r = $urandom_range(0, 99);
			if (r < 45)
				m = grow ? INS_MODES[$urandom_range(0, 2)] : DEL_MODES[$urandom_range(0, 2)];
			else if (r < 65)
				m = grow ? DEL_MODES[$urandom_range(0, 2)] : INS_MODES[$urandom_range(0, 2)];
			else if (r < 85)
				m = MODE_SEARCH;
			else
				m = MODE_READ;
			// mostly legal positions, sometimes anywhere
			if ($urandom_range(0, 4) != 0) begin
				span = $urandom_range(0, list_len);
				ix = IDX_W'((span > 15) ? 15 : span);
			end else begin
				ix = IDX_W'($urandom);
			end
			if (m == MODE_SEARCH && list_len > 0 && $urandom_range(0, 1) == 0)
				v = list_mem[$urandom_range(0, list_len - 1)];
			else
				v = pick_value();
			send_word(m, ix, v, 0, none);
		end
		drain_results();
		repeat (5) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 2));
			style_left = $urandom_range(20, 200);
		end
		style_left--;
		case (stall_style)
		STALL_NONE:   out_stall <= 1'b0;
		STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
		default: begin
			if (run_left == 0) begin
				stall_on = !stall_on;
				run_left = stall_on ? $urandom_range(1, 40) : $urandom_range(1, 10);
			end
			run_left--;
			out_stall <= stall_on;
		end
		endcase
	end

	// compare each delivered word with the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: status %0d, found %0d, value %0d, fill %0d",
					$time, status, found_index, read_value, fill_count);
			end else begin
				want = pending.pop_front();
				check_field("status", (VAL_W+1)'(want.status), (VAL_W+1)'(status));
				check_field("found_index", (VAL_W+1)'(want.found_index),
					(VAL_W+1)'(found_index));
				check_field("read_value", (VAL_W+1)'(want.read_value),
					(VAL_W+1)'(read_value));
				check_field("fill_count", (VAL_W+1)'(want.fill_count),
					(VAL_W+1)'(fill_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule
